// ===== src/idle_pull_cost_budget_top_assert.svh =====
// Assertion macros for the idle pull cost budget checker.
`ifndef IDLE_PULL_COST_BUDGET_TOP_ASSERT_SVH
`define IDLE_PULL_COST_BUDGET_TOP_ASSERT_SVH

// Clocked check, off while reset is asserted.
`define IPCB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked check that also covers reset.
`define IPCB_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== src/ipcb_pkg.sv =====
// Package: types, codes, constants and helpers of the idle pull cost budget.
`default_nettype none
package ipcb_pkg;

    localparam int LEVELS_DEF  = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_COST_FLOOR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_PERIOD = 2'd1;

    localparam logic [CFG_DATA_W-1:0] COST_FLOOR_RST   = 32'd500000;
    localparam logic [CFG_DATA_W-1:0] DECAY_PERIOD_RST = 32'd1000000000;
    localparam logic [63:0]           AVG_IDLE_RST     = 64'd1000000;
    localparam logic [63:0]           WORST_PULL_RST   = 64'd500000;

    localparam logic [2:0] FUNC_BEGIN  = 3'd0;
    localparam logic [2:0] FUNC_CHARGE = 3'd1;
    localparam logic [2:0] FUNC_TICK   = 3'd2;
    localparam logic [2:0] FUNC_LEAVE  = 3'd3;
    localparam logic [2:0] FUNC_FINISH = 3'd4;

    localparam logic [2:0] OP_NOP    = 3'd0;
    localparam logic [2:0] OP_BEGIN  = 3'd1;
    localparam logic [2:0] OP_CHARGE = 3'd2;
    localparam logic [2:0] OP_TICK   = 3'd3;
    localparam logic [2:0] OP_LEAVE  = 3'd4;
    localparam logic [2:0] OP_FINISH = 3'd5;

    typedef struct packed {
        logic [2:0]  func;
        logic [63:0] now_ns;
        logic [1:0]  level;
        logic [63:0] cost_ns;
    } in_item_t;

    typedef struct packed {
        logic [63:0] avg_idle_ns;
        logic [63:0] worst_pull_ns;
        logic [63:0] cost_cache_ns;
        logic [63:0] cost_node_ns;
        logic [63:0] cost_system_ns;
    } out_item_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [1:0]  level;
        logic [63:0] now_ns;
        logic [63:0] cost_ns;
    } cmd_t;

    function automatic logic [63:0] scale_253(input logic [63:0] c);
        logic [63:0] hi;
        logic [15:0] lo;
        hi = 64'({8'd0, c[63:8]} * 64'd253);
        lo = 16'({8'd0, c[7:0]} * 16'd253);
        return hi + {56'd0, lo[15:8]};
    endfunction

endpackage
`default_nettype wire

// ===== src/ipcb_front.sv =====
// Front end: accept input transactions and classify them into commands.
`default_nettype none
module ipcb_front
    import ipcb_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEF
) (
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    input  wire logic     q_full,
    output logic          q_push,
    output cmd_t          q_cmd
);

    logic lvl_ok;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;
    assign lvl_ok  = {30'd0, s_data.level} < 32'(LEVELS);

    always_comb begin
        q_cmd.level   = s_data.level;
        q_cmd.now_ns  = s_data.now_ns;
        q_cmd.cost_ns = s_data.cost_ns;
        unique case (s_data.func)
            FUNC_BEGIN:  q_cmd.op = OP_BEGIN;
            FUNC_CHARGE: q_cmd.op = lvl_ok ? OP_CHARGE : OP_NOP;
            FUNC_TICK:   q_cmd.op = OP_TICK;
            FUNC_LEAVE:  q_cmd.op = OP_LEAVE;
            FUNC_FINISH: q_cmd.op = OP_FINISH;
            default:     q_cmd.op = OP_NOP;
        endcase
    end

endmodule
`default_nettype wire

// ===== src/ipcb_queue.sv =====
// Command queue between front end and back end.
`default_nettype none
module ipcb_queue
    import ipcb_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      valid,
    output cmd_t      pop_cmd
);

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full    = cnt_reg == QCNT_W'(QUEUE_DEPTH);
    assign valid   = cnt_reg != '0;
    assign pop_cmd = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== src/ipcb_back.sv =====
// Back end: budget state, configuration registers and result register.
`default_nettype none
module ipcb_back
    import ipcb_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  q_valid,
    input  wire cmd_t                  q_cmd,
    output logic                       q_pop,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data
);

    localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    logic [63:0]           cost_reg  [LEVELS];
    logic [63:0]           cost_next [LEVELS];
    logic [63:0]           stamp_reg [LEVELS];
    logic [63:0]           stamp_next[LEVELS];
    logic [63:0]           scaled    [LEVELS];
    logic [LEVELS-1:0]     stale;
    logic [63:0]           avg_reg, avg_next;
    logic [63:0]           worst_reg, worst_next;
    logic [63:0]           start_reg, start_next;
    logic [CFG_DATA_W-1:0] floor_reg, period_reg;
    logic                  tick_pend_reg, tick_pend_next;
    logic                  tick_dec_reg, tick_dec_next;
    logic                  m_valid_reg, m_valid_next;
    out_item_t             m_data_reg, m_data_next;
    logic                  out_free, do_pop, finish_tick;
    logic [3:0]            lvl_ext;
    logic [LVL_W-1:0]      idx;
    logic [63:0]           period64, floor64;
    logic [63:0]           idle, step, avg_mid, cap, sat_sum;
    logic [66:0]           sum;
    logic [63:0]           view [3];

    assign out_free    = !m_valid_reg || m_ready;
    assign do_pop      = q_valid && out_free && !tick_pend_reg;
    assign finish_tick = tick_pend_reg && out_free;
    assign q_pop       = do_pop;
    assign m_valid     = m_valid_reg;
    assign m_data      = m_data_reg;
    assign lvl_ext     = {2'b00, q_cmd.level};
    assign idx         = lvl_ext[LVL_W-1:0];
    assign period64    = {32'd0, period_reg};
    assign floor64     = {32'd0, floor_reg};

    always_comb begin
        logic [63:0] due;
        logic [63:0] diff;
        for (int i = 0; i < LEVELS; i++) begin
            due       = stamp_reg[i] + period64;
            diff      = due - q_cmd.now_ns;
            stale[i]  = diff[63];
            scaled[i] = scale_253(cost_reg[i]);
        end
    end

    always_comb begin
        sum = '0;
        for (int i = 0; i < LEVELS; i++) begin
            sum = sum + {3'b000, cost_reg[i]};
        end
        sat_sum = (sum[66:64] != 3'b000) ? '1 : sum[63:0];
    end

    always_comb begin
        idle = q_cmd.now_ns - start_reg;
        if (idle > avg_reg) begin
            step    = (idle - avg_reg) >> 3;
            avg_mid = avg_reg + step;
        end else begin
            step    = (avg_reg - idle) >> 3;
            avg_mid = avg_reg - step;
        end
        cap = worst_reg[63] ? '1 : {worst_reg[62:0], 1'b0};
    end

    always_comb begin
        for (int i = 0; i < LEVELS; i++) begin
            cost_next[i]  = cost_reg[i];
            stamp_next[i] = stamp_reg[i];
        end
        avg_next       = avg_reg;
        worst_next     = worst_reg;
        start_next     = start_reg;
        tick_pend_next = tick_pend_reg;
        tick_dec_next  = tick_dec_reg;
        if (do_pop) begin
            unique case (q_cmd.op)
                OP_BEGIN: begin
                    start_next = q_cmd.now_ns;
                end
                OP_CHARGE: begin
                    if (q_cmd.cost_ns > cost_reg[idx]) begin
                        cost_next[idx]  = q_cmd.cost_ns;
                        stamp_next[idx] = q_cmd.now_ns;
                    end else if (stale[idx]) begin
                        cost_next[idx]  = scaled[idx];
                        stamp_next[idx] = q_cmd.now_ns;
                    end
                end
                OP_TICK: begin
                    for (int i = 0; i < LEVELS; i++) begin
                        if (stale[i]) begin
                            cost_next[i]  = scaled[i];
                            stamp_next[i] = q_cmd.now_ns;
                        end
                    end
                    tick_pend_next = 1'b1;
                    tick_dec_next  = |stale;
                end
                OP_LEAVE: begin
                    avg_next   = (avg_mid > cap) ? cap : avg_mid;
                    start_next = '0;
                end
                OP_FINISH: begin
                    if (q_cmd.cost_ns > worst_reg) begin
                        worst_next = q_cmd.cost_ns;
                    end
                end
                default: begin
                end
            endcase
        end else if (finish_tick) begin
            tick_pend_next = 1'b0;
            if (tick_dec_reg) begin
                worst_next = (sat_sum > floor64) ? sat_sum : floor64;
            end
        end
    end

    for (genvar j = 0; j < 3; j++) begin : g_view
        if (j < LEVELS) begin : g_on
            assign view[j] = cost_next[j];
        end else begin : g_off
            assign view[j] = '0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if ((do_pop && q_cmd.op != OP_TICK) || finish_tick) begin
            m_valid_next               = 1'b1;
            m_data_next.avg_idle_ns    = avg_next;
            m_data_next.worst_pull_ns  = worst_next;
            m_data_next.cost_cache_ns  = view[0];
            m_data_next.cost_node_ns   = view[1];
            m_data_next.cost_system_ns = view[2];
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LEVELS; i++) begin
                cost_reg[i]  <= '0;
                stamp_reg[i] <= '0;
            end
            avg_reg       <= AVG_IDLE_RST;
            worst_reg     <= WORST_PULL_RST;
            start_reg     <= '0;
            floor_reg     <= COST_FLOOR_RST;
            period_reg    <= DECAY_PERIOD_RST;
            tick_pend_reg <= 1'b0;
            tick_dec_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            for (int i = 0; i < LEVELS; i++) begin
                cost_reg[i]  <= cost_next[i];
                stamp_reg[i] <= stamp_next[i];
            end
            avg_reg       <= avg_next;
            worst_reg     <= worst_next;
            start_reg     <= start_next;
            tick_pend_reg <= tick_pend_next;
            tick_dec_reg  <= tick_dec_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_idx)
                    CFG_COST_FLOOR:   floor_reg  <= cfg_wdata;
                    CFG_DECAY_PERIOD: period_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule
`default_nettype wire

// ===== src/idle_pull_cost_budget_top.sv =====
// Top level of the idle pull cost budget block.
//
// Input channel s_valid/s_ready/s_data carries one event transaction (begin idle,
// charge level, decay tick, leave idle, finish pull). Result channel
// m_valid/m_ready/m_data returns one transaction per event: the average idle
// period, the worst pull cost and the three level costs after the event.
// cfg_we/cfg_idx/cfg_wdata write the cost floor (index 0) and decay period
// (index 1); write only while no event is in flight.
// An event passes through the command queue, then the result register holds its result;
// a decay tick decays the level costs first and runs its level-sum refresh as a
// second back end step. Throughput: one transaction per cycle while the receiver
// is ready; each tick holds the back end for its extra refresh step.
// A two-entry command queue sits between front and back end. When the receiver
// stalls, the result register holds, the queue fills and s_ready drops.
// Reset (aresetn low, synchronous) clears level costs and stamps, sets the
// average idle to 1000000 and the worst pull to 500000, restores both
// configuration registers and empties queue and result register.
`default_nettype none
module idle_pull_cost_budget_top
    import ipcb_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data
);

    logic q_full, q_push, q_valid, q_pop;
    cmd_t push_cmd, pop_cmd;

    ipcb_front #(
        .LEVELS(LEVELS)
    ) u_front (
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .q_full (q_full),
        .q_push (q_push),
        .q_cmd  (push_cmd)
    );

    ipcb_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_cmd(push_cmd),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .pop_cmd (pop_cmd)
    );

    ipcb_back #(
        .LEVELS(LEVELS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_wdata(cfg_wdata),
        .q_valid  (q_valid),
        .q_cmd    (pop_cmd),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
`default_nettype wire

// ===== src/ipcb_chk.sv =====
// Port-level checker for the idle pull cost budget top level, with its bind.
`default_nettype none
`include "idle_pull_cost_budget_top_assert.svh"
module ipcb_chk
    import ipcb_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_valid,
    input wire logic                  s_ready,
    input wire in_item_t              s_data,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire out_item_t             m_data
);

    logic [2:0] pending_reg, pending_next;
    logic       in_acc, out_acc;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    always_comb begin
        pending_next = pending_reg;
        if (in_acc && !out_acc) begin
            pending_next = pending_reg + 1'b1;
        end else if (out_acc && !in_acc) begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    `IPCB_ASSERT_RST(a_reset_idle, !aresetn |=> !m_valid && s_ready, "not idle after reset")
    `IPCB_ASSERT(a_in_hold, s_valid && !s_ready |=> s_valid && $stable(s_data), "input dropped")
    `IPCB_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_data), "result lost")
    `IPCB_ASSERT(a_no_phantom, m_valid |-> pending_reg != 3'd0, "result without transaction")
    `IPCB_ASSERT(a_ready_full, !s_ready |-> pending_reg >= 3'd2, "stall with empty queue")

endmodule

bind idle_pull_cost_budget_top ipcb_chk u_chk (.*);
`default_nettype wire

// ===== tb/idle_pull_cost_budget_top_test.sv =====
// Testbench for idle_pull_cost_budget_top: drives event transactions and checks each budget result.
`default_nettype none
module idle_pull_cost_budget_top_test;
    import ipcb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
    localparam logic [1:0] LEVEL_CACHE   = 2'd0;
    localparam logic [1:0] LEVEL_NODE    = 2'd1;
    localparam logic [1:0] LEVEL_SYSTEM  = 2'd2;
    localparam logic [1:0] LEVEL_INVALID = 2'd3;
    localparam logic [2:0] FUNC_UNKNOWN_FIRST = 3'd5;
    localparam logic [2:0] FUNC_UNKNOWN_LAST  = 3'd7;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int NUM_LEVELS = 3;
    localparam int PHASE_ITEMS = 300;
    localparam int HOLDOFF_CYCLES = 300;

    class cost_budget_tracker;
        logic [63:0] level_cost [NUM_LEVELS];
        logic [63:0] level_stamp [NUM_LEVELS];
        logic [63:0] mean_idle;
        logic [63:0] worst_pull;
        logic [63:0] idle_start;
        logic [31:0] cost_floor;
        logic [31:0] decay_period;
        out_item_t   due_budgets [$];
        int          errors;
        int          matched;
        int          func_seen [8];

        function new();
            errors = 0;
            matched = 0;
            foreach (func_seen[i]) func_seen[i] = 0;
            foreach (level_cost[i]) begin
                level_cost[i] = '0;
                level_stamp[i] = '0;
            end
            cost_floor = 32'd500000;
            decay_period = 32'd1000000000;
            mean_idle = {31'd0, cost_floor, 1'b0};
            worst_pull = {32'd0, cost_floor};
            idle_start = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                CFG_COST_FLOOR:   cost_floor = data;
                CFG_DECAY_PERIOD: decay_period = data;
                default: ;
            endcase
        endfunction

        function bit later(logic [63:0] a, logic [63:0] b);
            logic [63:0] d;
            d = b - a;
            return d[63];
        endfunction

        function logic [63:0] decayed_cost(logic [63:0] c);
            logic [71:0] p;
            p = {8'd0, c} * 72'd253;
            return p[71:8];
        endfunction

        function bit stale(int i, logic [63:0] now);
            return later(now, level_stamp[i] + {32'd0, decay_period});
        endfunction

        function void note_event(in_item_t ev);
            logic [64:0] sum;
            logic [63:0] idle;
            logic [63:0] cap;
            bit          decayed;
            out_item_t   want;
            func_seen[ev.func]++;
            case (ev.func)
                FUNC_BEGIN: idle_start = ev.now_ns;
                FUNC_CHARGE: begin
                    if (ev.level < NUM_LEVELS) begin
                        if (ev.cost_ns > level_cost[ev.level]) begin
                            level_cost[ev.level] = ev.cost_ns;
                            level_stamp[ev.level] = ev.now_ns;
                        end else if (stale(int'(ev.level), ev.now_ns)) begin
                            level_cost[ev.level] = decayed_cost(level_cost[ev.level]);
                            level_stamp[ev.level] = ev.now_ns;
                        end
                    end
                end
                FUNC_TICK: begin
                    decayed = 1'b0;
                    sum = '0;
                    for (int i = 0; i < NUM_LEVELS; i++) begin
                        if (stale(i, ev.now_ns)) begin
                            level_cost[i] = decayed_cost(level_cost[i]);
                            level_stamp[i] = ev.now_ns;
                            decayed = 1'b1;
                        end
                        sum = sum + {1'b0, level_cost[i]};
                        if (sum[64]) sum = {1'b0, ALL_ONES};
                    end
                    if (decayed)
                        worst_pull = (sum[63:0] > {32'd0, cost_floor}) ? sum[63:0]
                                                                       : {32'd0, cost_floor};
                end
                FUNC_LEAVE: begin
                    idle = ev.now_ns - idle_start;
                    cap = worst_pull[63] ? ALL_ONES : {worst_pull[62:0], 1'b0};
                    if (idle > mean_idle)
                        mean_idle = mean_idle + ((idle - mean_idle) >> 3);
                    else
                        mean_idle = mean_idle - ((mean_idle - idle) >> 3);
                    if (mean_idle > cap) mean_idle = cap;
                    idle_start = '0;
                end
                FUNC_FINISH: begin
                    if (ev.cost_ns > worst_pull) worst_pull = ev.cost_ns;
                end
                default: ;
            endcase
            want.avg_idle_ns = mean_idle;
            want.worst_pull_ns = worst_pull;
            want.cost_cache_ns = level_cost[LEVEL_CACHE];
            want.cost_node_ns = level_cost[LEVEL_NODE];
            want.cost_system_ns = level_cost[LEVEL_SYSTEM];
            due_budgets.push_back(want);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            end
        endfunction

        function void check_budget(out_item_t got);
            out_item_t want;
            if (due_budgets.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none actual %h", $time, got);
                return;
            end
            want = due_budgets.pop_front();
            matched++;
            compare_field("avg_idle_ns", want.avg_idle_ns, got.avg_idle_ns);
            compare_field("worst_pull_ns", want.worst_pull_ns, got.worst_pull_ns);
            compare_field("cost_cache_ns", want.cost_cache_ns, got.cost_cache_ns);
            compare_field("cost_node_ns", want.cost_node_ns, got.cost_node_ns);
            compare_field("cost_system_ns", want.cost_system_ns, got.cost_system_ns);
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;

    cost_budget_tracker budget;
    logic [63:0] clock_ns = '0;
    bit          quiet = 1'b0;
    bit          stall_hold = 1'b0;
    int          sent = 0;
    int          settings = 0;

    idle_pull_cost_budget_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) budget.note_event(s_data);
            if (m_valid && m_ready) budget.check_budget(m_data);
        end
    end

    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            if (stall_hold) begin
                m_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge aclk);
                stall_hold = 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    initial begin
        #(12 * 400000);
        $display("idle_pull_cost_budget_top_test failed");
        $finish;
    end

    function automatic in_item_t mk(logic [2:0] f, logic [63:0] now, logic [1:0] lv,
                                    logic [63:0] c);
        in_item_t ev;
        ev.func = f;
        ev.now_ns = now;
        ev.level = lv;
        ev.cost_ns = c;
        return ev;
    endfunction

    function automatic logic [63:0] rand_cost();
        logic [63:0] v;
        int          w;
        v = {$urandom, $urandom};
        w = $urandom_range(0, 64);
        return v >> (64 - w);
    endfunction

    function automatic void advance_time();
        logic [63:0] span;
        span = {32'd0, budget.decay_period};
        case ($urandom_range(0, 19))
            0: clock_ns = clock_ns + {$urandom, $urandom};
            1: ;
            2, 3, 4: clock_ns = clock_ns + $urandom_range(0, 1000);
            5, 6, 7, 8: clock_ns = clock_ns + span - 64'd2 + $urandom_range(0, 4);
            default: clock_ns = clock_ns + ((span * $urandom_range(1, 96)) >> 6);
        endcase
    endfunction

    task automatic offer(in_item_t ev);
        s_valid <= 1'b1;
        s_data <= ev;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    task automatic send(in_item_t ev);
        offer(ev);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (budget.due_budgets.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        budget.write_reg(idx, data);
    endtask

    task automatic configure(logic [31:0] floor_ns, logic [31:0] period_ns);
        set_reg(CFG_COST_FLOOR, floor_ns);
        set_reg(CFG_DECAY_PERIOD, period_ns);
        set_reg(CFG_SPARE_2, $urandom);
        set_reg(CFG_SPARE_3, $urandom);
        cfg_we <= 1'b0;
        settings++;
    endtask

    task automatic run_episode();
        logic [63:0] total;
        logic [63:0] c;
        total = '0;
        advance_time();
        send(mk(FUNC_BEGIN, clock_ns, 2'($urandom_range(0, 3)), rand_cost()));
        repeat ($urandom_range(0, 6)) begin
            advance_time();
            c = rand_cost();
            total = total + c;
            if ($urandom_range(0, 5) == 0)
                send(mk(FUNC_TICK, clock_ns, 2'($urandom_range(0, 3)), c));
            else if ($urandom_range(0, 15) == 0)
                send(mk(FUNC_CHARGE, clock_ns, LEVEL_INVALID, c));
            else
                send(mk(FUNC_CHARGE, clock_ns, 2'($urandom_range(0, 2)), c));
        end
        advance_time();
        if ($urandom_range(0, 3) == 0) total = rand_cost();
        send(mk(FUNC_FINISH, clock_ns, 2'($urandom_range(0, 3)), total));
        advance_time();
        send(mk(FUNC_LEAVE, clock_ns, 2'($urandom_range(0, 3)), rand_cost()));
    endtask

    task automatic send_noise();
        advance_time();
        send(mk(3'($urandom_range(0, 7)),
                $urandom_range(0, 1) ? {$urandom, $urandom} : clock_ns,
                2'($urandom_range(0, 3)), {$urandom, $urandom}));
    endtask

    task automatic run_directed();
        send(mk(FUNC_TICK, 64'd0, LEVEL_CACHE, 64'd0));
        send(mk(FUNC_BEGIN, 64'd1000, LEVEL_CACHE, 64'd0));
        send(mk(FUNC_LEAVE, 64'd5001000, LEVEL_CACHE, 64'd0));
        send(mk(FUNC_LEAVE, 64'd10, LEVEL_CACHE, 64'd0));
        send(mk(FUNC_CHARGE, 64'd20, LEVEL_CACHE, ALL_ONES));
        send(mk(FUNC_CHARGE, 64'd30, LEVEL_NODE, 64'd0));
        send(mk(FUNC_CHARGE, 64'd40, LEVEL_SYSTEM, 64'd123456789));
        send(mk(FUNC_CHARGE, 64'd50, LEVEL_INVALID, ALL_ONES));
        send(mk(FUNC_CHARGE, 64'd60, LEVEL_CACHE, 64'd5));
        send(mk(FUNC_CHARGE, 64'd1000000020, LEVEL_CACHE, 64'd5));
        send(mk(FUNC_CHARGE, 64'd1000000021, LEVEL_CACHE, 64'd5));
        send(mk(FUNC_CHARGE, 64'd1000000030, LEVEL_SYSTEM, ALL_ONES));
        send(mk(FUNC_TICK, 64'h4000_0000_0000_0000, LEVEL_CACHE, 64'd0));
        send(mk(FUNC_LEAVE, 64'h4000_0000_0000_0000, LEVEL_CACHE, 64'd0));
        send(mk(FUNC_FINISH, 64'h4000_0000_0000_0001, LEVEL_CACHE, 64'd0));
        send(mk(FUNC_FINISH, 64'h4000_0000_0000_0002, LEVEL_CACHE, ALL_ONES));
        for (int f = FUNC_UNKNOWN_FIRST; f <= FUNC_UNKNOWN_LAST; f++)
            send(mk(3'(f), ALL_ONES, LEVEL_INVALID, ALL_ONES));
        send(mk(FUNC_BEGIN, 64'hFFFF_FFFF_FFFF_FF00, LEVEL_CACHE, 64'd0));
        send(mk(FUNC_LEAVE, 64'h0000_0000_0000_0100, LEVEL_CACHE, 64'd0));
        send(mk(FUNC_CHARGE, 64'hFFFF_FFFF_FFFF_FFF0, LEVEL_NODE, 64'd7));
        send(mk(FUNC_CHARGE, 64'd1000000000, LEVEL_NODE, 64'd1));
        send(mk(FUNC_TICK, 64'h8000_0000_0000_0000, LEVEL_CACHE, 64'd0));
        send(mk(FUNC_TICK, 64'h8000_0000_0000_0001, LEVEL_SYSTEM, 64'd0));
    endtask

    initial begin
        logic [31:0] floors [5];
        logic [31:0] periods [5];
        int          target;
        int          unknown_seen;
        budget = new();
        floors[0] = 32'd0;
        periods[0] = 32'd1;
        floors[1] = 32'hFFFF_FFFF;
        periods[1] = 32'hFFFF_FFFF;
        floors[2] = $urandom;
        periods[2] = $urandom_range(1, 5000);
        floors[3] = 32'd500000;
        periods[3] = 32'd1000000;
        floors[4] = $urandom;
        periods[4] = $urandom_range(1, 32'hFFFF_FFFF);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        drain();

        for (int p = 0; p < 5; p++) begin
            configure(floors[p], periods[p]);
            if (p == 4) quiet = 1'b1;
            clock_ns = {$urandom, $urandom};
            target = sent + PHASE_ITEMS;
            if (p == 1) begin
                stall_hold = 1'b1;
                repeat (40) begin
                    advance_time();
                    offer(mk(FUNC_CHARGE, clock_ns, 2'($urandom_range(0, 2)), rand_cost()));
                end
            end
            while (sent < target) begin
                if ($urandom_range(0, 9) == 0)
                    send_noise();
                else
                    run_episode();
            end
            drain();
        end

        repeat (10) @(posedge aclk);
        unknown_seen = 0;
        for (int f = FUNC_UNKNOWN_FIRST; f <= FUNC_UNKNOWN_LAST; f++)
            unknown_seen += budget.func_seen[f];
        $display("Run covered %0d events: begin %0d, charge %0d, tick %0d, leave %0d, finish %0d,",
                 sent, budget.func_seen[FUNC_BEGIN], budget.func_seen[FUNC_CHARGE],
                 budget.func_seen[FUNC_TICK], budget.func_seen[FUNC_LEAVE],
                 budget.func_seen[FUNC_FINISH]);
        $display("unknown %0d, across %0d register settings, with %0d results checked.",
                 unknown_seen, settings + 1, budget.matched);
        if (budget.errors == 0 && budget.due_budgets.size() == 0)
            $display("idle_pull_cost_budget_top_test passed");
        else
            $display("idle_pull_cost_budget_top_test failed");
        $finish;
    end
endmodule
`default_nettype wire
